### sv/tbc_pkg.sv
// shared constants, types and the latin-1 fold table for the text byte converter
package tbc_pkg;

    // conversion modes
    localparam logic [2:0] MODE_CR     = 3'd0;
    localparam logic [2:0] MODE_LF     = 3'd1;
    localparam logic [2:0] MODE_CRLF   = 3'd2;
    localparam logic [2:0] MODE_CLR_HI = 3'd3;
    localparam logic [2:0] MODE_SET_HI = 3'd4;
    localparam logic [2:0] MODE_TABS   = 3'd5;
    localparam logic [2:0] MODE_ACCENT = 3'd6;

    // character codes
    localparam logic [6:0] CH_CR    = 7'd13;
    localparam logic [6:0] CH_LF    = 7'd10;
    localparam logic [6:0] CH_TAB   = 7'd9;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_S_LO  = 8'h73;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // utf-8 byte classes
    localparam logic [7:0] HI_BIT      = 8'h80;
    localparam logic [7:0] LEAD_MIN    = 8'hC0;
    localparam logic [7:0] LEAD_LATIN  = 8'hC3;
    localparam logic [7:0] LEAD_THREE  = 8'hE0;
    localparam logic [7:0] LEAD_FOUR   = 8'hF0;
    localparam logic [7:0] LEAD_END    = 8'hF8;
    localparam logic [7:0] SHARP_S     = 8'h9F;
    localparam logic [7:0] LOWER_START = 8'hA0;

    // controller to datapath
    typedef struct packed {
        logic load;   // input item accepted, take its plan
        logic step;   // one result item taken
    } t_tbc_cmd;

    // datapath to controller
    typedef struct packed {
        logic plan_none;  // incoming item makes no result
        logic cur_last;   // result on the output is the final one of its item
    } t_tbc_sts;

    // ascii fold of latin-1 c0..df, indexed by the low five bits; upper case but for index 31 (y)
    function automatic logic [7:0] latin_fold(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6: ch = "A";
            5'd7:                                    ch = "C";
            5'd8, 5'd9, 5'd10, 5'd11:                ch = "E";
            5'd12, 5'd13, 5'd14, 5'd15:              ch = "I";
            5'd16:                                   ch = "D";
            5'd17:                                   ch = "N";
            5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd24: ch = "O";
            5'd25, 5'd26, 5'd27, 5'd28:              ch = "U";
            5'd29:                                   ch = "Y";
            5'd31:                                   ch = "y";
            default:                                 ch = "?";
        endcase
        return ch;
    endfunction

endpackage

### sv/tbc_if.sv
// valid/ready channel interfaces for input and result items
interface tbc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] in_byte;

    modport source (output valid, output operation, output in_byte, input ready);
    modport sink   (input valid, input operation, input in_byte, output ready);
endinterface

interface tbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

### sv/tbc_ctrl.sv
// handshake controller: idle / emit state machine
module tbc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  tbc_pkg::t_tbc_sts   i_sts,
    output tbc_pkg::t_tbc_cmd   o_cmd
);
    import tbc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state;
    logic n_state;
    logic w_take_last;

    // a final result taken frees the input in the same cycle
    assign o_out_valid = (r_state == ST_EMIT);
    assign w_take_last = o_out_valid && i_out_ready && i_sts.cur_last;
    assign o_in_ready  = (r_state == ST_IDLE) || w_take_last;

    // commands
    assign o_cmd.load = i_in_valid && o_in_ready;
    assign o_cmd.step = o_out_valid && i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load && !i_sts.plan_none) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (o_cmd.load) begin
                    n_state = i_sts.plan_none ? ST_IDLE : ST_EMIT;
                end else if (w_take_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/tbc_dp.sv
// datapath: mode register, stream state, output plan and result byte selection
module tbc_dp #(
    parameter int TAB_WIDTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbc_pkg::t_tbc_cmd   i_cmd,
    output tbc_pkg::t_tbc_sts   o_sts,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_data,
    input  logic                i_operation,
    input  logic [7:0]          i_in_byte,
    output logic [7:0]          o_out_byte,
    output logic                o_last
);
    import tbc_pkg::*;

    localparam int COL_W = $clog2(TAB_WIDTH);
    localparam int CNT_W = $clog2(TAB_WIDTH + 1);

    // configuration and stream state
    logic [2:0]       r_mode;
    logic             r_prev_cr,  n_prev_cr;
    logic [COL_W-1:0] r_column,   n_column;
    logic [1:0]       r_pending,  n_pending;
    logic             r_lead_lat, n_lead_lat;

    // output plan: optional prefix byte, then a run of one repeated byte
    logic             r_pre_vld,  n_pre_vld;
    logic [7:0]       r_pre_byte, n_pre_byte;
    logic [7:0]       r_rep_byte, n_rep_byte;
    logic [CNT_W-1:0] r_rep_cnt,  n_rep_cnt;

    logic [6:0]       w_low;
    logic [7:0]       w_hb;
    logic [7:0]       w_fold;
    logic [7:0]       w_latin;
    logic [COL_W-1:0] w_col_inc;
    logic [1:0]       w_pend;

    assign w_low = i_in_byte[6:0];
    assign w_hb  = i_in_byte & HI_BIT;

    // latin-1 fold with lower-casing and sharp s
    assign w_fold = latin_fold(i_in_byte[4:0]);
    always_comb begin
        w_latin = w_fold;
        if (i_in_byte == SHARP_S) begin
            w_latin = CH_S_LO;
        end else if (i_in_byte >= LOWER_START && w_fold >= CH_A_UP && w_fold <= CH_Z_UP) begin
            w_latin = w_fold | CASE_BIT;
        end
    end

    // column advance, wraps at the tab stop
    assign w_col_inc = (r_column == COL_W'(TAB_WIDTH - 1)) ? '0 : r_column + 1'b1;

    // plan and next stream state for the incoming item
    always_comb begin
        n_prev_cr  = r_prev_cr;
        n_column   = r_column;
        n_pending  = r_pending;
        n_lead_lat = r_lead_lat;
        n_pre_vld  = 1'b0;
        n_pre_byte = CH_QUERY;
        n_rep_byte = i_in_byte;
        n_rep_cnt  = '0;
        w_pend     = r_pending;
        if (i_operation) begin
            // end of stream
            if (r_mode == MODE_ACCENT && r_pending != 2'd0) begin
                n_rep_byte = CH_QUERY;
                n_rep_cnt  = CNT_W'(1);
            end
            n_prev_cr = 1'b0;
            n_column  = '0;
            n_pending = 2'd0;
        end else begin
            unique case (r_mode) inside
                MODE_CR, MODE_LF, MODE_CRLF: begin
                    if (w_low == CH_CR || (w_low == CH_LF && !r_prev_cr)) begin
                        n_rep_cnt = CNT_W'(1);
                        if (r_mode == MODE_CR) begin
                            n_rep_byte = {1'b0, CH_CR} | w_hb;
                        end else begin
                            n_rep_byte = {1'b0, CH_LF} | w_hb;
                        end
                        if (r_mode == MODE_CRLF) begin
                            n_pre_vld  = 1'b1;
                            n_pre_byte = {1'b0, CH_CR} | w_hb;
                        end
                    end else if (w_low != CH_LF) begin
                        n_rep_cnt = CNT_W'(1);
                    end
                    n_prev_cr = (w_low == CH_CR);
                end
                MODE_CLR_HI: begin
                    n_rep_byte = {1'b0, w_low};
                    n_rep_cnt  = CNT_W'(1);
                end
                MODE_SET_HI: begin
                    n_rep_byte = i_in_byte | HI_BIT;
                    n_rep_cnt  = CNT_W'(1);
                end
                MODE_TABS: begin
                    if (w_low == CH_TAB) begin
                        n_rep_byte = CH_SPACE | w_hb;
                        n_rep_cnt  = CNT_W'(TAB_WIDTH) - CNT_W'(r_column);
                        n_column   = '0;
                    end else begin
                        n_rep_cnt = CNT_W'(1);
                        n_column  = (w_low == CH_CR || w_low == CH_LF) ? '0 : w_col_inc;
                    end
                end
                MODE_ACCENT: begin
                    // broken sequence: flag it and treat the byte afresh
                    if (r_pending != 2'd0 && i_in_byte[7:6] != 2'b10) begin
                        n_pre_vld = 1'b1;
                        w_pend    = 2'd0;
                    end
                    n_pending = w_pend;
                    if (w_pend != 2'd0) begin
                        n_pending = w_pend - 2'd1;
                        if (r_lead_lat) begin
                            n_rep_byte = w_latin;
                            n_rep_cnt  = CNT_W'(1);
                        end else if (w_pend == 2'd1) begin
                            n_rep_byte = CH_QUERY;
                            n_rep_cnt  = CNT_W'(1);
                        end
                    end else if (!i_in_byte[7]) begin
                        n_rep_cnt = CNT_W'(1);
                    end else if (i_in_byte >= LEAD_MIN && i_in_byte < LEAD_END) begin
                        n_lead_lat = (i_in_byte == LEAD_LATIN);
                        if (i_in_byte >= LEAD_FOUR) begin
                            n_pending = 2'd3;
                        end else if (i_in_byte >= LEAD_THREE) begin
                            n_pending = 2'd2;
                        end else begin
                            n_pending = 2'd1;
                        end
                    end else begin
                        n_rep_byte = CH_QUERY;
                        n_rep_cnt  = CNT_W'(1);
                    end
                end
                default: begin
                    n_rep_cnt = CNT_W'(1);
                end
            endcase
        end
    end

    // status
    assign o_sts.plan_none = !n_pre_vld && (n_rep_cnt == '0);
    assign o_sts.cur_last  = r_pre_vld ? (r_rep_cnt == '0) : (r_rep_cnt == CNT_W'(1));

    // result byte
    assign o_out_byte = r_pre_vld ? r_pre_byte : r_rep_byte;
    assign o_last     = o_sts.cur_last;

    // mode register and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_CR;
            r_prev_cr  <= 1'b0;
            r_column   <= '0;
            r_pending  <= 2'd0;
            r_lead_lat <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_prev_cr  <= n_prev_cr;
                r_column   <= n_column;
                r_pending  <= n_pending;
                r_lead_lat <= n_lead_lat;
            end
        end
    end

    // output plan, consumed one result item at a time
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pre_vld  <= n_pre_vld;
            r_pre_byte <= n_pre_byte;
            r_rep_byte <= n_rep_byte;
            r_rep_cnt  <= n_rep_cnt;
        end else if (i_cmd.step) begin
            if (r_pre_vld) begin
                r_pre_vld <= 1'b0;
            end else begin
                r_rep_cnt <= r_rep_cnt - 1'b1;
            end
        end
    end

endmodule

### sv/text_byte_converter_core.sv
// top level of the text byte converter: line endings, high bit, tabs, utf-8 folding
// A result item appears in the cycle after its input item is accepted.
// Throughput: one result item per cycle while the output is ready; an input item making
// several results holds the input until its final result leaves (a tab up to TAB_WIDTH, a crlf two).
// The output plan register paces this: the next item enters as the final result leaves.
// Reset (synchronous, active low) clears mode to 0 and all stream state; no result pending.
module text_byte_converter_core #(
    parameter int TAB_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbc_in_if.sink      i_in,
    tbc_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data
);
    import tbc_pkg::*;

    t_tbc_cmd w_cmd;
    t_tbc_sts w_sts;

    // handshake controller
    tbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // conversion datapath
    tbc_dp #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_operation (i_in.operation),
        .i_in_byte   (i_in.in_byte),
        .o_out_byte  (o_out.out_byte),
        .o_last      (o_out.last)
    );

endmodule

### sv/tbc_checker.sv
// port-level checks for the text byte converter and their binding
module tbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item withdrawn while stalled");

    // nothing is offered straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item offered after reset");

    // input opens during a burst only as its final item leaves
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_last && i_out_ready)
        else $error("input taken while results of an item remain");

    // once the final item leaves with no new input, output goes quiet
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last && !(i_in_valid && i_in_ready)
        |=> !i_out_valid)
        else $error("result item appeared with no input item");

endmodule

bind text_byte_converter_core tbc_checker u_tbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last)
);
